@@ src/fcp_pkg.sv @@
package fcp_pkg;

    // Field position wrap limits: a position returns to zero when it would exceed these.
    localparam int unsigned TYPE_WRAP    = 5;
    localparam int unsigned SENDER_WRAP  = 10;
    localparam int unsigned COMMAND_WRAP = 2;
    localparam int unsigned MESSAGE_WRAP = 50;

    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // Reset values of the configuration registers
    localparam logic [7:0] START_RESET = 8'h26;
    localparam logic [7:0] STOP_RESET  = 8'h24;
    localparam logic [7:0] SEP_RESET   = 8'h3A;

    // Acknowledge characters
    localparam logic [7:0] ACK_OPEN    = 8'h26;  // '&'
    localparam logic [7:0] ACK_LBRACK  = 8'h5B;  // '['
    localparam logic [7:0] ACK_LETTER  = 8'h41;  // 'A'
    localparam logic [7:0] ACK_RBRACK  = 8'h5D;  // ']'
    localparam logic [7:0] ACK_CLOSE   = 8'h24;  // '$'

    // Acknowledge beat sequence
    localparam logic [2:0] ACK_STEP_OPEN   = 3'd0;
    localparam logic [2:0] ACK_STEP_LBRACK = 3'd1;
    localparam logic [2:0] ACK_STEP_LETTER = 3'd2;
    localparam logic [2:0] ACK_STEP_RBRACK = 3'd3;
    localparam logic [2:0] ACK_STEP_HI     = 3'd4;
    localparam logic [2:0] ACK_STEP_LO     = 3'd5;
    localparam logic [2:0] ACK_STEP_CLOSE  = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_STOP  = 2'd1;
    localparam logic [1:0] CFG_SEP   = 2'd2;

    typedef enum logic [3:0] {
        KIND_GATED   = 4'd0,
        KIND_IDLE    = 4'd1,
        KIND_START   = 4'd2,
        KIND_TYPE    = 4'd3,
        KIND_SENDER  = 4'd4,
        KIND_SEP     = 4'd5,
        KIND_COUNT   = 4'd6,
        KIND_COMMAND = 4'd7,
        KIND_MESSAGE = 4'd8,
        KIND_RECORD  = 4'd9,
        KIND_ID      = 4'd10,
        KIND_ACK     = 4'd11
    } kind_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] separator_byte;
    } fcp_cfg_t;

    // First result of one input beat, plus what the acknowledge sequencer needs.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [5:0] pos;
        logic [7:0] rec;
        logic       ready;
        logic       ack;
        logic [7:0] ack_id;
    } fcp_result_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'd0, nib};
        else
            ch = 8'h57 + {4'd0, nib};
        return ch;
    endfunction

    function automatic logic [7:0] ack_char(input logic [2:0] step, input logic [7:0] id);
        logic [7:0] ch;
        case (step)
            ACK_STEP_OPEN:   ch = ACK_OPEN;
            ACK_STEP_LBRACK: ch = ACK_LBRACK;
            ACK_STEP_LETTER: ch = ACK_LETTER;
            ACK_STEP_RBRACK: ch = ACK_RBRACK;
            ACK_STEP_HI:     ch = hex_char(id[7:4]);
            ACK_STEP_LO:     ch = hex_char(id[3:0]);
            ACK_STEP_CLOSE:  ch = ACK_CLOSE;
            default:         ch = ACK_CLOSE;
        endcase
        return ch;
    endfunction

endpackage

@@ src/fcp_rx_if.sv @@
interface fcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/fcp_res_if.sv @@
interface fcp_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_kind;
    logic [7:0] out_byte;
    logic [5:0] field_pos;
    logic [7:0] record_index;
    logic       message_ready;
    logic       last;

    modport source (output valid, output out_kind, output out_byte, output field_pos,
                    output record_index, output message_ready, output last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input field_pos,
                  input record_index, input message_ready, input last, output ready);
endinterface

@@ src/fcp_cfg_if.sv @@
interface fcp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/fcp_parser.sv @@
module fcp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    input  fcp_pkg::fcp_cfg_t   cfg,
    output fcp_pkg::fcp_result_t res
);
    import fcp_pkg::*;

    typedef enum logic [2:0] {
        ST_WAIT    = 3'd0,
        ST_TYPE    = 3'd1,
        ST_SENDER  = 3'd2,
        ST_BLOCK   = 3'd3,
        ST_COMMAND = 3'd4,
        ST_MESSAGE = 3'd5,
        ST_END     = 3'd6
    } state_t;

    state_t     state_reg, state_next;
    logic       gate_reg, gate_next;
    logic       ready_reg, ready_next;
    logic [2:0] type_pos_reg, type_pos_next;
    logic [3:0] sender_pos_reg, sender_pos_next;
    logic [1:0] command_pos_reg, command_pos_next;
    logic [5:0] message_pos_reg, message_pos_next;
    logic [7:0] records_reg, records_next;
    logic [7:0] id_reg, id_next;

    logic       gate_eff;
    logic       is_stop;
    logic       is_sep;
    logic [3:0] type_inc;
    logic [4:0] sender_inc;
    logic [2:0] command_inc;
    logic [6:0] message_inc;
    logic [7:0] records_dec;
    logic [7:0] digit;

    assign type_inc    = {1'b0, type_pos_reg} + 4'd1;
    assign sender_inc  = {1'b0, sender_pos_reg} + 5'd1;
    assign command_inc = {1'b0, command_pos_reg} + 3'd1;
    assign message_inc = {1'b0, message_pos_reg} + 7'd1;
    assign records_dec = records_reg - 8'd1;
    assign digit       = rx_byte - DIGIT_BASE;
    assign is_stop     = (rx_byte == cfg.stop_byte);
    assign is_sep      = (rx_byte == cfg.separator_byte);
    assign gate_eff    = gate_reg || (rx_byte == cfg.start_byte);

    always_comb
    begin
        state_next       = state_reg;
        ready_next       = ready_reg;
        type_pos_next    = type_pos_reg;
        sender_pos_next  = sender_pos_reg;
        command_pos_next = command_pos_reg;
        message_pos_next = message_pos_reg;
        records_next     = records_reg;
        id_next          = id_reg;
        gate_next        = is_stop ? 1'b0 : gate_eff;

        res        = '0;
        res.kind   = KIND_GATED;
        res.data   = rx_byte;
        res.ack_id = id_reg;

        if (is_stop || gate_eff)
        begin
            case (state_reg)
                ST_WAIT:
                begin
                    if (rx_byte == cfg.start_byte)
                    begin
                        type_pos_next   = '0;
                        sender_pos_next = '0;
                        records_next    = '0;
                        ready_next      = 1'b0;
                        state_next      = ST_TYPE;
                        res.kind        = KIND_START;
                    end
                    else
                    begin
                        res.kind = KIND_IDLE;
                    end
                end
                ST_TYPE:
                begin
                    if (is_sep)
                    begin
                        state_next = ST_SENDER;
                        res.kind   = KIND_SEP;
                    end
                    else
                    begin
                        type_pos_next = (type_inc > 4'(TYPE_WRAP)) ? '0 : type_inc[2:0];
                        res.kind      = KIND_TYPE;
                        res.pos       = {3'd0, type_pos_reg};
                    end
                end
                ST_SENDER:
                begin
                    if (is_sep)
                    begin
                        state_next = ST_BLOCK;
                        res.kind   = KIND_SEP;
                    end
                    else
                    begin
                        sender_pos_next = (sender_inc > 5'(SENDER_WRAP)) ? '0 : sender_inc[3:0];
                        res.kind        = KIND_SENDER;
                        res.pos         = {2'd0, sender_pos_reg};
                    end
                end
                ST_BLOCK:
                begin
                    if (is_sep)
                    begin
                        state_next = ST_COMMAND;
                        res.kind   = KIND_SEP;
                    end
                    else
                    begin
                        records_next = digit;
                        res.kind     = KIND_COUNT;
                        res.data     = digit;
                    end
                end
                ST_COMMAND:
                begin
                    if (is_sep)
                    begin
                        state_next = ST_MESSAGE;
                        res.kind   = KIND_SEP;
                    end
                    else
                    begin
                        command_pos_next = (command_inc > 3'(COMMAND_WRAP)) ? '0
                                                                             : command_inc[1:0];
                        res.kind         = KIND_COMMAND;
                        res.pos          = {4'd0, command_pos_reg};
                    end
                end
                ST_MESSAGE:
                begin
                    if (is_sep)
                    begin
                        // Record done: count down and restart the per-record positions
                        records_next     = records_dec;
                        command_pos_next = '0;
                        message_pos_next = '0;
                        state_next       = (records_dec == 8'd0) ? ST_END : ST_COMMAND;
                        res.kind         = KIND_RECORD;
                        res.rec          = records_dec;
                    end
                    else
                    begin
                        message_pos_next = (message_inc > 7'(MESSAGE_WRAP)) ? '0
                                                                             : message_inc[5:0];
                        res.kind         = KIND_MESSAGE;
                        res.pos          = message_pos_reg;
                    end
                end
                ST_END:
                begin
                    if (is_stop)
                    begin
                        state_next = ST_WAIT;
                        res.kind   = KIND_ACK;
                        res.data   = ACK_OPEN;
                        res.ack    = 1'b1;
                    end
                    else
                    begin
                        id_next  = digit;
                        res.kind = KIND_ID;
                        res.data = digit;
                    end
                end
                default:
                begin
                    state_next = ST_WAIT;
                    res.kind   = KIND_IDLE;
                end
            endcase
        end

        if (is_stop)
            ready_next = 1'b1;
        res.ready = ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_WAIT;
            gate_reg        <= 1'b0;
            ready_reg       <= 1'b0;
            type_pos_reg    <= '0;
            sender_pos_reg  <= '0;
            command_pos_reg <= '0;
            message_pos_reg <= '0;
            records_reg     <= '0;
            id_reg          <= '0;
        end
        else if (take)
        begin
            state_reg       <= state_next;
            gate_reg        <= gate_next;
            ready_reg       <= ready_next;
            type_pos_reg    <= type_pos_next;
            sender_pos_reg  <= sender_pos_next;
            command_pos_reg <= command_pos_next;
            message_pos_reg <= message_pos_next;
            records_reg     <= records_next;
            id_reg          <= id_next;
        end
    end

endmodule

@@ src/framed_command_parser.sv @@
// Framed command parser.
//
// rx carries one received byte per beat. cfg writes the start, stop and
// separator bytes (index 0, 1, 2); it is always ready. The user must write
// it only while the block is idle, which is not enforced. res carries one
// labeled result per beat; last marks the final result from an input byte.
//
// The result of a byte is on res in the cycle after its rx beat. One byte per
// cycle while res takes each result and no acknowledge run is pending. A stop
// byte that closes a frame in the end state makes six or seven acknowledge
// beats ('&', '[', 'A', ']', the id in hex, '$'); rx is held off until the
// sequencer has loaded the last of them. The output register parts the two
// sides: outside an acknowledge run, a new byte is taken in the same cycle
// the waiting result is taken.
//
// Reset clears the parser to waiting for a start byte with the gate closed,
// the configuration to '&', '$', ':', and empties the output register.
// When the receiver stalls, the result holds in the output register and rx
// ready drops until the result is taken.
module framed_command_parser (
    input  logic clk,
    input  logic rst_n,
    fcp_rx_if.sink    rx,
    fcp_res_if.source res,
    fcp_cfg_if.sink   cfg
);
    import fcp_pkg::*;

    fcp_cfg_t    cfg_reg;
    fcp_result_t parsed;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    logic [5:0]  pos_reg;
    logic [7:0]  rec_reg;
    logic        ready_flag_reg;
    logic        last_reg;

    logic        ack_busy_reg;
    logic [2:0]  ack_step_reg;
    logic [2:0]  ack_step_next;
    logic [7:0]  ack_id_reg;

    logic        rx_fire;
    logic        out_fire;

    // Configuration registers: the port never stalls; unknown indexes drop.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte     <= START_RESET;
            cfg_reg.stop_byte      <= STOP_RESET;
            cfg_reg.separator_byte <= SEP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START: cfg_reg.start_byte     <= cfg.data;
                CFG_STOP:  cfg_reg.stop_byte      <= cfg.data;
                CFG_SEP:   cfg_reg.separator_byte <= cfg.data;
                default:   cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Take a byte when no acknowledge run is pending and the output register
    // is empty or being emptied this cycle.
    assign out_fire = out_valid_reg && res.ready;
    assign rx.ready = !ack_busy_reg && (!out_valid_reg || res.ready);
    assign rx_fire  = rx.valid && rx.ready;

    fcp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (rx_fire),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .res     (parsed)
    );

    // Skip the high hex digit when the id fits in one digit.
    assign ack_step_next = (ack_step_reg == ACK_STEP_RBRACK && ack_id_reg < 8'd16)
                         ? ACK_STEP_LO : ack_step_reg + 3'd1;

    // Control: output valid and the acknowledge sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ack_busy_reg  <= 1'b0;
            ack_step_reg  <= ACK_STEP_OPEN;
        end
        else if (rx_fire)
        begin
            out_valid_reg <= 1'b1;
            ack_busy_reg  <= parsed.ack;
            ack_step_reg  <= ACK_STEP_LBRACK;
        end
        else if (out_fire)
        begin
            if (ack_busy_reg)
            begin
                // Advance to the next acknowledge beat; the last one ends the run.
                ack_busy_reg <= (ack_step_reg != ACK_STEP_CLOSE);
                ack_step_reg <= ack_step_next;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            kind_reg       <= parsed.kind;
            byte_reg       <= parsed.data;
            pos_reg        <= parsed.pos;
            rec_reg        <= parsed.rec;
            ready_flag_reg <= parsed.ready;
            last_reg       <= !parsed.ack;
            ack_id_reg     <= parsed.ack_id;
        end
        else if (out_fire && ack_busy_reg)
        begin
            // Kind, position, record index and ready flag hold from the first beat.
            byte_reg <= ack_char(ack_step_reg, ack_id_reg);
            last_reg <= (ack_step_reg == ACK_STEP_CLOSE);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.out_kind      = kind_reg;
    assign res.out_byte      = byte_reg;
    assign res.field_pos     = pos_reg;
    assign res.record_index  = rec_reg;
    assign res.message_ready = ready_flag_reg;
    assign res.last          = last_reg;

    // A pending acknowledge run always has a beat on show.
    a_busy_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        ack_busy_reg |-> out_valid_reg)
        else $error("acknowledge run pending with empty output register");

    // No byte is taken while an acknowledge run is pending.
    a_busy_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        ack_busy_reg |-> !rx_fire)
        else $error("byte taken during acknowledge run");

    // Beats of an acknowledge run are acknowledge kind, never last, ready set.
    a_busy_beat_form: assert property (@(posedge clk) disable iff (!rst_n)
        ack_busy_reg |-> (kind_reg == KIND_ACK && !last_reg && ready_flag_reg))
        else $error("malformed beat inside acknowledge run");

    // The run ends right after the closing character has been loaded.
    a_run_ends_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && ack_busy_reg && ack_step_reg == ACK_STEP_CLOSE && !rx_fire)
        |=> (!ack_busy_reg && last_reg && byte_reg == ACK_CLOSE))
        else $error("acknowledge run did not end on closing character");

    // The sequencer step never goes past the closing character.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ack_busy_reg |-> (ack_step_reg != 3'd7 && ack_step_reg != ACK_STEP_OPEN))
        else $error("acknowledge step out of range");

endmodule
